// ===== hdl/icp_pkg.sv =====
// ----------------------------------------------------------------------------
// icp_pkg - shared types and constants of the ipv4 cidr text parser
// character codes, field indexes, accumulator limits and the result word
// ----------------------------------------------------------------------------
package icp_pkg;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // field index codes: 0..3 octets, 4 prefix
  localparam logic [2:0] FIELD_FIRST  = 3'd0;
  localparam logic [2:0] FIELD_FOURTH = 3'd3;
  localparam logic [2:0] FIELD_PREFIX = 3'd4;

  localparam logic [8:0] ACC_MAX_OCTET = 9'd255;
  localparam logic [8:0] ACC_SAT       = 9'd256;
  localparam logic [8:0] PREFIX_MIN    = 9'd1;
  localparam logic [8:0] PREFIX_MAX    = 9'd32;

  localparam logic        PREFIX_MODE_RESET = 1'b1;

  typedef struct packed {
    logic fire;  // registered character is processed this cycle
    logic last;  // that character ends the string
  } icp_step_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
    logic [31:0] netmask;
    logic [31:0] broadcast;
    logic [5:0]  prefix_length;
  } icp_res_t;

endpackage

// ===== hdl/icp_channels.sv =====
// ----------------------------------------------------------------------------
// icp_channels - handshake channels of the ipv4 cidr text parser
// character input, result output and mode register write channel
// ----------------------------------------------------------------------------
interface icp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface icp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] address;
  logic [31:0] netmask;
  logic [31:0] broadcast;
  logic [5:0]  prefix_length;

  modport source (output valid, output valid_res, output address, output netmask,
                  output broadcast, output prefix_length, input ready);
  modport sink   (input valid, input valid_res, input address, input netmask,
                  input broadcast, input prefix_length, output ready);
endinterface

interface icp_cfg_if;
  logic valid;
  logic ready;
  logic prefix_mode;

  modport source (output valid, output prefix_mode, input ready);
  modport sink   (input valid, input prefix_mode, output ready);
endinterface

// ===== hdl/icp_parse_core.sv =====
// ----------------------------------------------------------------------------
// icp_parse_core - per-character parse state and result formation
// holds field index, octets and accumulator; builds the result on the last char
// ----------------------------------------------------------------------------
module icp_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  icp_pkg::icp_step_t step_i,
  input  logic [7:0]        char_code_i,
  input  logic              prefix_mode_i,
  output icp_pkg::icp_res_t res_o
);

  logic [2:0]  field_q, field_d;
  logic [8:0]  acc_q, acc_d;
  logic        err_q, err_d;
  logic [7:0]  oct_q [3];
  logic [7:0]  oct_d [3];
  logic [7:0]  oct4_q, oct4_d;

  logic        is_digit;
  logic [11:0] acc_next;
  logic        ok;
  logic [7:0]  o3;
  logic [31:0] addr;
  logic [31:0] mask;
  logic [4:0]  shamt;
  logic [5:0]  shamt_full;

  assign is_digit = (char_code_i >= icp_pkg::CHAR_ZERO) && (char_code_i <= icp_pkg::CHAR_NINE);
  // acc * 10 + digit
  assign acc_next = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1)
                  + {4'b0000, char_code_i - icp_pkg::CHAR_ZERO};

  always_comb begin
    field_d = field_q;
    acc_d   = acc_q;
    err_d   = err_q;
    oct_d   = oct_q;
    oct4_d  = oct4_q;
    if (!err_q) begin
      if (char_code_i == icp_pkg::CHAR_DOT && field_q < icp_pkg::FIELD_FOURTH) begin
        if (acc_q > icp_pkg::ACC_MAX_OCTET) err_d = 1'b1;
        case (field_q[1:0])
          2'd0:    oct_d[0] = acc_q[7:0];
          2'd1:    oct_d[1] = acc_q[7:0];
          default: oct_d[2] = acc_q[7:0];
        endcase
        acc_d   = '0;
        field_d = field_q + 3'd1;
      end else if (char_code_i == icp_pkg::CHAR_SLASH && prefix_mode_i &&
                   field_q == icp_pkg::FIELD_FOURTH) begin
        if (acc_q > icp_pkg::ACC_MAX_OCTET) err_d = 1'b1;
        oct4_d  = acc_q[7:0];
        acc_d   = '0;
        field_d = icp_pkg::FIELD_PREFIX;
      end else if (is_digit) begin
        acc_d = (acc_next > {3'b000, icp_pkg::ACC_MAX_OCTET}) ? icp_pkg::ACC_SAT
                                                               : acc_next[8:0];
      end else begin
        err_d = 1'b1;
      end
    end
  end

  // final check on the updated state
  always_comb begin
    if (prefix_mode_i) begin
      ok = !err_d && field_d == icp_pkg::FIELD_PREFIX &&
           acc_d >= icp_pkg::PREFIX_MIN && acc_d <= icp_pkg::PREFIX_MAX;
      o3 = oct4_d;
    end else begin
      ok = !err_d && field_d == icp_pkg::FIELD_FOURTH && acc_d <= icp_pkg::ACC_MAX_OCTET;
      o3 = acc_d[7:0];
    end
    addr       = {oct_d[0], oct_d[1], oct_d[2], o3};
    shamt_full = 6'd32 - acc_d[5:0];
    shamt      = shamt_full[4:0];
    mask       = 32'hFFFF_FFFF << shamt;

    res_o = '0;
    if (ok) begin
      res_o.valid_res = 1'b1;
      res_o.address   = addr;
      if (prefix_mode_i) begin
        res_o.netmask       = mask;
        res_o.broadcast     = addr | ~mask;
        res_o.prefix_length = acc_d[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= icp_pkg::FIELD_FIRST;
      acc_q   <= '0;
      err_q   <= 1'b0;
      oct_q   <= '{default: 8'h00};
      oct4_q  <= '0;
    end else if (step_i.fire) begin
      if (step_i.last) begin
        field_q <= icp_pkg::FIELD_FIRST;
        acc_q   <= '0;
        err_q   <= 1'b0;
        oct_q   <= '{default: 8'h00};
        oct4_q  <= '0;
      end else begin
        field_q <= field_d;
        acc_q   <= acc_d;
        err_q   <= err_d;
        oct_q   <= oct_d;
        oct4_q  <= oct4_d;
      end
    end
  end

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q <= icp_pkg::FIELD_PREFIX) else $error("field index out of range");

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= icp_pkg::ACC_SAT) else $error("accumulator above saturation");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.fire && !res_o.valid_res) |-> (res_o.address == '0 && res_o.netmask == '0 &&
      res_o.prefix_length == '0)) else $error("invalid result carries data");

endmodule

// ===== hdl/ipv4_cidr_text_parser.sv =====
// ----------------------------------------------------------------------------
// ipv4_cidr_text_parser - streaming dotted quad / cidr text parser
// input register, per-character parse core and result register
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                          handshake
//  cfg_i     in   prefix_mode                                      valid/ready
//  in_i      in   char_code, last_char                             valid/ready
//  out_o     out  valid_res, address, netmask, broadcast,          valid/ready
//                 prefix_length
//
//  one character word is taken every cycle while input is not stalled; the parse
//  core updates its state from the input register, and the result word of a last
//  char is captured in the result register, from which it can be taken;
//  only a last character waiting on a full, untaken result register stalls input
//  cfg_i is always ready; prefix_mode resets to 1
//  rst_ni clears parse state and both valid flags and sets the mode asynchronously
//
module ipv4_cidr_text_parser (
  input  logic clk_i,
  input  logic rst_ni,
  icp_cfg_if.sink   cfg_i,
  icp_in_if.sink    in_i,
  icp_out_if.source out_o
);

  // mode register
  logic mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= icp_pkg::PREFIX_MODE_RESET;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.prefix_mode;
    end
  end

  // input register
  logic       in_v_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       out_v_q;
  logic       proc;

  // a non-last char never touches the result register, so it always proceeds
  assign proc       = in_v_q && (!last_q || !out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.char_code;
      last_q <= in_i.last_char;
    end
  end

  // parse core
  icp_pkg::icp_step_t step;
  icp_pkg::icp_res_t  res;
  icp_pkg::icp_res_t  res_q;

  assign step = '{fire: proc, last: last_q};

  icp_parse_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .char_code_i   (char_q),
    .prefix_mode_i (mode_q),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (proc && last_q) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_q) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.valid_res     = res_q.valid_res;
  assign out_o.address       = res_q.address;
  assign out_o.netmask       = res_q.netmask;
  assign out_o.broadcast     = res_q.broadcast;
  assign out_o.prefix_length = res_q.prefix_length;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && last_q) |=> out_v_q) else $error("last char gave no result");

  a_held_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !proc) |=> (in_v_q && $stable(char_q) && $stable(last_q)))
    else $error("stalled char lost");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !proc) |-> (last_q && out_v_q && !out_o.ready))
    else $error("input stalled without cause");

endmodule
